[rtl/core/css_pkg.sv]
// ----------------------------------------------------------------------------
// css_pkg
// Shared types, constants and step-table helpers for the clocked step
// sequencer gate.
// ----------------------------------------------------------------------------
`default_nettype none

package css_pkg;

	localparam int NUM_STEPS   = 8;
	localparam int STEP_W      = 3;
	localparam int PULSE_W     = 4;
	localparam int TICK_W      = 24;
	localparam int GLEN_W      = 28;
	localparam int PITCH_W     = 8;
	localparam int FRAC_W      = 8;
	localparam int MODE_W      = 2;
	localparam int PROD_W      = 32;
	localparam int RECIP_W     = 30;
	localparam int RECIP_SHIFT = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;

	localparam logic [NUM_STEPS-1:0] LIVE_MASK      = NUM_STEPS'((1 << NUM_STEPS) - 1);
	localparam logic [TICK_W-1:0]    TICK_MAX       = '1;
	localparam logic [TICK_W-1:0]    DEFAULT_PERIOD = TICK_W'(5000);
	localparam logic [PULSE_W-1:0]   PULSE_MAX      = '1;

	// hold gate: ceil(x * 19 / 20) = floor((x * 19 + 19) / 4 / 5)
	localparam int                   HOLD_NUM   = 19;
	localparam logic [RECIP_W-1:0]   RECIP_FIVE = 30'h3333_3334;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_COUNTS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_MODES   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_PITCHES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GATE_FRAC    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOOPING      = 3'd5;

	// gate modes
	localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MULTI  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SILENT = 2'd3;

	typedef struct packed {
		logic [NUM_STEPS-1:0]          enable_mask;
		logic [3*NUM_STEPS-1:0]        pulse_counts;
		logic [MODE_W*NUM_STEPS-1:0]   gate_modes;
		logic [PITCH_W*NUM_STEPS-1:0]  step_pitches;
		logic [FRAC_W-1:0]             gate_fraction;
		logic                          looping;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic mul;
		logic recip;
		logic close;
	} cmd_t;

	typedef struct packed {
		logic              found;
		logic [STEP_W-1:0] idx;
	} step_sel_t;

	function automatic logic [STEP_W-1:0] first_enabled(input logic [NUM_STEPS-1:0] mask);
		logic [STEP_W-1:0] idx;
		idx = '0;
		for (int s = NUM_STEPS - 1; s >= 0; s--) begin
			if (mask[s]) begin
				idx = STEP_W'(s);
			end
		end
		return idx;
	endfunction

	function automatic step_sel_t next_enabled(input logic [NUM_STEPS-1:0] mask,
	                                          input logic [STEP_W-1:0] cur);
		step_sel_t sel;
		sel = '0;
		for (int s = NUM_STEPS - 1; s >= 0; s--) begin
			if (mask[s] && (STEP_W'(s) > cur)) begin
				sel.found = 1'b1;
				sel.idx   = STEP_W'(s);
			end
		end
		return sel;
	endfunction

	function automatic logic [PULSE_W-1:0] pulses_of(input logic [3*NUM_STEPS-1:0] counts,
	                                                input logic [STEP_W-1:0] s);
		return {1'b0, counts[3*s +: 3]} + PULSE_W'(1);
	endfunction

	function automatic logic [MODE_W-1:0] mode_of(input logic [MODE_W*NUM_STEPS-1:0] modes,
	                                             input logic [STEP_W-1:0] s);
		return modes[MODE_W*s +: MODE_W];
	endfunction

	function automatic logic [PITCH_W-1:0] pitch_of(
		input logic [PITCH_W*NUM_STEPS-1:0] pitches, input logic [STEP_W-1:0] s);
		return pitches[PITCH_W*s +: PITCH_W];
	endfunction

	function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
		return (v < TICK_MAX) ? v + TICK_W'(1) : TICK_MAX;
	endfunction

endpackage

`default_nettype wire

[rtl/core/css_cfg_regs.sv]
// ----------------------------------------------------------------------------
// css_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module css_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [css_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [css_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output css_pkg::cfg_t                         cfg
);
	import css_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_mask   <= '1;
			cfg_q.pulse_counts  <= '0;
			cfg_q.gate_modes    <= '0;
			cfg_q.step_pitches  <= '0;
			cfg_q.gate_fraction <= FRAC_W'(192);
			cfg_q.looping       <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_STEP_ENABLE:  cfg_q.enable_mask   <= cfg_wdata[NUM_STEPS-1:0];
				REG_PULSE_COUNTS: cfg_q.pulse_counts  <= cfg_wdata[3*NUM_STEPS-1:0];
				REG_GATE_MODES:   cfg_q.gate_modes    <= cfg_wdata[MODE_W*NUM_STEPS-1:0];
				REG_STEP_PITCHES: cfg_q.step_pitches  <= cfg_wdata[PITCH_W*NUM_STEPS-1:0];
				REG_GATE_FRAC:    cfg_q.gate_fraction <= cfg_wdata[FRAC_W-1:0];
				REG_LOOPING:      cfg_q.looping       <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/core/css_ctrl.sv]
// ----------------------------------------------------------------------------
// css_ctrl
// Sequencing controller: accepts one tick, walks it through evaluate,
// multiply, reciprocal and close, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module css_ctrl (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	output css_pkg::cmd_t  cmd
);
	import css_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_RECIP = 3'd3;
	localparam logic [2:0] ST_CLOSE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// the output slot can take a result this cycle
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.capture = s_tvalid && s_tready;
		cmd.eval    = (state_q == ST_EVAL);
		cmd.mul     = (state_q == ST_MUL);
		cmd.recip   = (state_q == ST_RECIP);
		cmd.close   = (state_q == ST_CLOSE) && out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (cmd.capture) state_d = ST_EVAL;
			ST_EVAL:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_RECIP;
			ST_RECIP: state_d = ST_CLOSE;
			ST_CLOSE: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.close) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/css_datapath.sv]
// ----------------------------------------------------------------------------
// css_datapath
// Sequencer state, edge detection, step advance, gate length arithmetic,
// gate timers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module css_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire css_pkg::cfg_t                 cfg,
	input  wire css_pkg::cmd_t                 cmd,
	input  wire logic                          clock_in,
	input  wire logic                          reset_in,
	input  wire logic                          start_in,
	input  wire logic                          stop_in,
	input  wire logic                          toggle_in,
	output logic                               gate_out,
	output logic                               end_gate_out,
	output logic                               running_out,
	output logic [css_pkg::STEP_W-1:0]         step_out,
	output logic [css_pkg::PITCH_W-1:0]        pitch_out
);
	import css_pkg::*;

	// captured tick
	logic clock_in_q, reset_in_q, start_in_q, stop_in_q, toggle_in_q;

	// sequencer state
	logic                 run_q, last_clock_q, last_reset_q, last_run_q, last_toggle_q;
	logic [STEP_W-1:0]    step_q;
	logic [PULSE_W-1:0]   pulse_q;
	logic                 gate_open_q, eg_open_q;
	logic [TICK_W-1:0]    tsc_q, prior_q, tsg_q, tseg_q, eglen_q;
	logic [GLEN_W-1:0]    glen_q;
	logic [PITCH_W-1:0]   held_pitch_q;
	logic                 load_q;
	logic [MODE_W-1:0]    mode_q;

	// gate length arithmetic
	logic [TICK_W-1:0]    p_q;
	logic [FRAC_W-1:0]    b_q;
	logic [PROD_W-1:0]    prod_q;
	logic [2*RECIP_W-1:0] rec_q;
	logic [TICK_W-1:0]    lin_q;
	logic [RECIP_W-1:0]   hold_y;

	// evaluate results
	logic [NUM_STEPS-1:0] live;
	step_sel_t            nxt;
	logic                 run_v, clk_v, prev_v, gate_open_v, eg_open_v, load_v;
	logic [STEP_W-1:0]    step_v;
	logic [PULSE_W-1:0]   pulse_v;
	logic [TICK_W-1:0]    tsc_v, prior_v, tsg_v, tseg_v, eglen_v, period_v, p_v;
	logic [PITCH_W-1:0]   held_v;
	logic [MODE_W-1:0]    mode_v;
	logic [FRAC_W-1:0]    b_v;

	// close results
	logic [GLEN_W-1:0]    glen_c;
	logic                 gate_open_c, eg_open_c;
	logic [TICK_W-1:0]    tsg_c, tseg_c;

	assign live = cfg.enable_mask & LIVE_MASK;

	always_comb begin
		run_v       = run_q ^ (toggle_in_q & ~last_toggle_q);
		run_v       = (run_v | start_in_q) & ~stop_in_q;
		step_v      = step_q;
		pulse_v     = pulse_q;
		gate_open_v = gate_open_q;
		eg_open_v   = eg_open_q;
		tseg_v      = tseg_q;
		eglen_v     = eglen_q;
		tsg_v       = tsg_q;
		held_v      = held_pitch_q;
		prior_v     = prior_q;
		clk_v       = clock_in_q;
		prev_v      = last_clock_q;
		tsc_v       = tsc_q;
		period_v    = tsc_q;
		load_v      = 1'b0;
		mode_v      = MODE_SINGLE;
		nxt         = '0;

		if (reset_in_q && !last_reset_q) begin
			step_v      = first_enabled(live);
			pulse_v     = '0;
			gate_open_v = 1'b0;
			eg_open_v   = 1'b0;
			run_v       = 1'b1;
		end

		// start of a run acts as a clock edge and restores the prior count
		if (run_v && !last_run_q) begin
			prev_v = 1'b0;
			clk_v  = 1'b1;
			tsc_v  = prior_q;
		end

		if (clk_v && !prev_v && (live != '0)) begin
			period_v = tsc_v;
			prior_v  = tsc_v;
			tsc_v    = '0;
			if (run_v) begin
				if (pulse_v >= pulses_of(cfg.pulse_counts, step_v)) begin
					pulse_v = '0;
					nxt     = next_enabled(live, step_v);
					if (nxt.found) begin
						step_v = nxt.idx;
					end else begin
						step_v = first_enabled(live);
						if (!eg_open_v) begin
							tseg_v    = '0;
							eglen_v   = period_v;
							eg_open_v = 1'b1;
						end
						if (!cfg.looping) begin
							run_v = 1'b0;
						end
					end
				end
				if (run_v) begin
					tsg_v  = '0;
					mode_v = mode_of(cfg.gate_modes, step_v);
					if ((pulse_v == '0) || (mode_v == MODE_MULTI)) begin
						load_v      = 1'b1;
						gate_open_v = (mode_v != MODE_SILENT);
					end
					held_v = pitch_of(cfg.step_pitches, step_v);
					if (pulse_v != PULSE_MAX) begin
						pulse_v = pulse_v + PULSE_W'(1);
					end
				end
			end
		end

		tsc_v = sat_inc(tsc_v);
		p_v   = (period_v == '0) ? DEFAULT_PERIOD : period_v;
		b_v   = (mode_v == MODE_HOLD)
		        ? FRAC_W'(pulses_of(cfg.pulse_counts, step_v) * HOLD_NUM)
		        : cfg.gate_fraction;
	end

	assign hold_y = RECIP_W'((33'(prod_q) + 33'(HOLD_NUM)) >> 2);

	always_comb begin
		glen_c = glen_q;
		if (load_q) begin
			priority if (mode_q == MODE_SILENT) begin
				glen_c = '0;
			end else if (mode_q == MODE_HOLD) begin
				glen_c = rec_q[RECIP_SHIFT +: GLEN_W];
			end else begin
				glen_c = GLEN_W'(lin_q);
			end
		end
		gate_open_c = gate_open_q;
		tsg_c       = tsg_q;
		if (gate_open_q) begin
			if (GLEN_W'(tsg_q) >= glen_c) begin
				gate_open_c = 1'b0;
			end
			tsg_c = sat_inc(tsg_q);
		end
		eg_open_c = eg_open_q;
		tseg_c    = tseg_q;
		if (eg_open_q) begin
			if (tseg_q >= eglen_q) begin
				eg_open_c = 1'b0;
			end
			tseg_c = sat_inc(tseg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q         <= 1'b0;
			last_clock_q  <= 1'b0;
			last_reset_q  <= 1'b0;
			last_run_q    <= 1'b0;
			last_toggle_q <= 1'b0;
			step_q        <= '0;
			pulse_q       <= '0;
			gate_open_q   <= 1'b0;
			eg_open_q     <= 1'b0;
			tsc_q         <= '0;
			prior_q       <= '0;
			tsg_q         <= '0;
			glen_q        <= '0;
			tseg_q        <= '0;
			eglen_q       <= '0;
			held_pitch_q  <= '0;
			load_q        <= 1'b0;
			mode_q        <= MODE_SINGLE;
		end else if (cmd.eval) begin
			run_q         <= run_v;
			last_clock_q  <= clk_v;
			last_reset_q  <= reset_in_q;
			last_run_q    <= run_v;
			last_toggle_q <= toggle_in_q;
			step_q        <= step_v;
			pulse_q       <= pulse_v;
			gate_open_q   <= gate_open_v;
			eg_open_q     <= eg_open_v;
			tsc_q         <= tsc_v;
			prior_q       <= prior_v;
			tsg_q         <= tsg_v;
			tseg_q        <= tseg_v;
			eglen_q       <= eglen_v;
			held_pitch_q  <= held_v;
			load_q        <= load_v;
			mode_q        <= mode_v;
		end else if (cmd.close) begin
			glen_q      <= glen_c;
			gate_open_q <= gate_open_c;
			tsg_q       <= tsg_c;
			eg_open_q   <= eg_open_c;
			tseg_q      <= tseg_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			clock_in_q  <= clock_in;
			reset_in_q  <= reset_in;
			start_in_q  <= start_in;
			stop_in_q   <= stop_in;
			toggle_in_q <= toggle_in;
		end
		if (cmd.eval) begin
			p_q <= p_v;
			b_q <= b_v;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(p_q) * PROD_W'(b_q);
		end
		// divide by 20: quarter, then reciprocal of five
		if (cmd.recip) begin
			rec_q <= (2*RECIP_W)'(hold_y) * (2*RECIP_W)'(RECIP_FIVE);
			lin_q <= TICK_W'((33'(prod_q) + 33'(255)) >> FRAC_W);
		end
		if (cmd.close) begin
			gate_out     <= run_q & gate_open_c;
			end_gate_out <= eg_open_c;
			running_out  <= run_q;
			step_out     <= step_q;
			pitch_out    <= run_q ? held_pitch_q : '0;
		end
	end

endmodule

`default_nettype wire

[rtl/core/clocked_step_sequencer_gate.sv]
// ----------------------------------------------------------------------------
// clocked_step_sequencer_gate
// Step sequencer with clock period measurement and per-step gate modes.
//
// channel   dir   handshake          payload
// s_*       in    tvalid / tready    tdata: clock, reset, start, stop, toggle
// m_*       out   tvalid / tready    tdata: gate, end gate, running, step, pitch
// cfg_*     in    cfg_we             cfg_idx selects register, cfg_wdata value
//
// Each tick passes an accept state, then evaluate, multiply, reciprocal and
// close; a new tick is taken only after close. Multiply and reciprocal form
// the gate length (period times fraction or pulse factor, then a reciprocal
// multiply for the divide by twenty). Close holds while the output register
// still has an untaken result. arst_n clears sequencer state and loads register defaults at once.
// ----------------------------------------------------------------------------
`default_nettype none

module clocked_step_sequencer_gate (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// [0] clock_in [1] reset_in [2] start_in [3] stop_in [4] toggle_in
	input  wire logic [css_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// [0] gate_out [1] end_gate_out [2] running_out [5:3] step_out [13:6] pitch_out
	output logic [css_pkg::OUT_TDATA_W-1:0]          m_tdata,
	input  wire logic                                cfg_we,
	input  wire logic [css_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire logic [css_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import css_pkg::*;

	cfg_t               cfg;
	cmd_t               cmd;
	logic               gate_out, end_gate_out, running_out;
	logic [STEP_W-1:0]  step_out;
	logic [PITCH_W-1:0] pitch_out;

	css_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	css_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	css_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.clock_in     (s_tdata[0]),
		.reset_in     (s_tdata[1]),
		.start_in     (s_tdata[2]),
		.stop_in      (s_tdata[3]),
		.toggle_in    (s_tdata[4]),
		.gate_out     (gate_out),
		.end_gate_out (end_gate_out),
		.running_out  (running_out),
		.step_out     (step_out),
		.pitch_out    (pitch_out)
	);

	assign m_tdata = {2'b00, pitch_out, step_out, running_out, end_gate_out, gate_out};

endmodule

`default_nettype wire

[rtl/core/css_checker.sv]
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks for the clocked step sequencer gate, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module css_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	input  wire logic                                s_tready,
	input  wire logic                                m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic [css_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// one tick in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again before tick finished");

	// gate only while running
	a_gate_running: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[2])
		else $error("gate high while stopped");

	// pitch cleared while stopped
	a_pitch_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> (m_tdata[13:6] == 8'd0))
		else $error("pitch nonzero while stopped");

endmodule

bind clocked_step_sequencer_gate css_checker u_css_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clocked step sequencer gate. Sample ticks are
// streamed in with random gaps on both sides while a tick-accurate model of
// the sequencer predicts every output word and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import css_pkg::*;

	class step_seq_checker;
		// register copies, reset values
		logic [NUM_STEPS-1:0]         enable_mask;
		logic [3*NUM_STEPS-1:0]       pulse_cfg;
		logic [MODE_W*NUM_STEPS-1:0]  mode_cfg;
		logic [PITCH_W*NUM_STEPS-1:0] pitch_cfg;
		logic [FRAC_W-1:0]            frac;
		logic                         loop_en;

		// sequencer state
		logic               running, prev_clock, prev_reset, prev_run, prev_toggle;
		logic [STEP_W-1:0]  step;
		logic [PULSE_W-1:0] pulse;
		logic               gate_on, end_on;
		logic [TICK_W-1:0]  since_clock, prior_period, period, since_gate, since_end, end_len;
		logic [GLEN_W-1:0]  gate_len;
		logic [PITCH_W-1:0] pitch;

		logic [OUT_TDATA_W-1:0] expected_outputs [$];
		int unsigned            mismatches;
		int unsigned            checked;

		function new();
			enable_mask  = '1;
			pulse_cfg    = '0;
			mode_cfg     = '0;
			pitch_cfg    = '0;
			frac         = FRAC_W'(192);
			loop_en      = 1'b1;
			running      = 1'b0;
			prev_clock   = 1'b0;
			prev_reset   = 1'b0;
			prev_run     = 1'b0;
			prev_toggle  = 1'b0;
			step         = '0;
			pulse        = '0;
			gate_on      = 1'b0;
			end_on       = 1'b0;
			since_clock  = '0;
			prior_period = '0;
			period       = '0;
			since_gate   = '0;
			since_end    = '0;
			end_len      = '0;
			gate_len     = '0;
			pitch        = '0;
			mismatches   = 0;
			checked      = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_STEP_ENABLE: begin
					enable_mask = v[NUM_STEPS-1:0];
				end
				REG_PULSE_COUNTS: begin
					pulse_cfg = v[3*NUM_STEPS-1:0];
				end
				REG_GATE_MODES: begin
					mode_cfg = v[MODE_W*NUM_STEPS-1:0];
				end
				REG_STEP_PITCHES: begin
					pitch_cfg = v[PITCH_W*NUM_STEPS-1:0];
				end
				REG_GATE_FRAC: begin
					frac = v[FRAC_W-1:0];
				end
				REG_LOOPING: begin
					loop_en = v[0];
				end
				default: begin
				end
			endcase
		endfunction

		function logic [STEP_W-1:0] first_live();
			logic [STEP_W-1:0] idx;
			idx = '0;
			for (int s = NUM_STEPS - 1; s >= 0; s--) begin
				if (enable_mask[s]) begin
					idx = STEP_W'(s);
				end
			end
			return idx;
		endfunction

		function logic [PULSE_W-1:0] pulses_for(input logic [STEP_W-1:0] s);
			return PULSE_W'(pulse_cfg[3*s +: 3]) + PULSE_W'(1);
		endfunction

		function logic [TICK_W-1:0] sat_tick(input logic [TICK_W-1:0] v);
			return (v == TICK_MAX) ? TICK_MAX : v + TICK_W'(1);
		endfunction

		// one accepted sample tick: advance the model and queue the output word
		function void note_tick(input logic [IN_TDATA_W-1:0] d);
			logic                   clk_lvl, pclk, rst_lvl, start_lvl, stop_lvl, tog_lvl;
			logic                   found;
			logic [MODE_W-1:0]      mode;
			longint unsigned        p;
			int                     s;
			logic [OUT_TDATA_W-1:0] out_word;
			clk_lvl   = d[0];
			rst_lvl   = d[1];
			start_lvl = d[2];
			stop_lvl  = d[3];
			tog_lvl   = d[4];
			pclk      = prev_clock;

			if (tog_lvl && !prev_toggle) begin
				running = !running;
			end
			prev_toggle = tog_lvl;
			running = (running || start_lvl) && !stop_lvl;

			if (rst_lvl && !prev_reset) begin
				step    = first_live();
				pulse   = '0;
				gate_on = 1'b0;
				end_on  = 1'b0;
				running = 1'b1;
			end

			// start of a run acts as a clock edge and brings back the old period count
			if (running && !prev_run) begin
				pclk        = 1'b0;
				clk_lvl     = 1'b1;
				since_clock = prior_period;
			end

			if (clk_lvl && !pclk && enable_mask != '0) begin
				period       = since_clock;
				prior_period = since_clock;
				since_clock  = '0;
				if (running && pulse >= pulses_for(step)) begin
					pulse = '0;
					found = 1'b0;
					for (s = int'(step) + 1; s < NUM_STEPS; s++) begin
						if (!found && enable_mask[s]) begin
							step  = STEP_W'(s);
							found = 1'b1;
						end
					end
					if (!found) begin
						step = first_live();
						if (!end_on) begin
							since_end = '0;
							end_len   = period;
							end_on    = 1'b1;
						end
						if (!loop_en) begin
							running = 1'b0;
						end
					end
				end
				if (running) begin
					since_gate = '0;
					mode = mode_cfg[MODE_W*step +: MODE_W];
					if (pulse == '0 || mode == MODE_MULTI) begin
						if (period == '0) begin
							period = DEFAULT_PERIOD;
						end
						p = period;
						if (mode == MODE_HOLD) begin
							gate_len = GLEN_W'((p * pulses_for(step) * 19 + 19) / 20);
						end else if (mode == MODE_SILENT) begin
							gate_len = '0;
						end else begin
							gate_len = GLEN_W'((p * frac + 255) / 256);
						end
						gate_on = (mode != MODE_SILENT);
					end
					pitch = pitch_cfg[PITCH_W*step +: PITCH_W];
					if (pulse != PULSE_MAX) begin
						pulse = pulse + PULSE_W'(1);
					end
				end
			end

			if (gate_on) begin
				if (GLEN_W'(since_gate) >= gate_len) begin
					gate_on = 1'b0;
				end
				since_gate = sat_tick(since_gate);
			end
			if (end_on) begin
				if (since_end >= end_len) begin
					end_on = 1'b0;
				end
				since_end = sat_tick(since_end);
			end

			out_word = {2'b00, running ? pitch : 8'h00, step, running, end_on,
				running & gate_on};
			expected_outputs = {expected_outputs, out_word};

			prev_clock  = clk_lvl;
			prev_reset  = rst_lvl;
			prev_run    = running;
			since_clock = sat_tick(since_clock);
		endfunction

		function void check_output(input logic [OUT_TDATA_W-1:0] got);
			logic [OUT_TDATA_W-1:0] want;
			if (expected_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("output %h arrived with nothing pending", got);
				end
				return;
			end
			want = expected_outputs.pop_front();
			checked++;
			if (got[0] !== want[0] || got[1] !== want[1] || got[2] !== want[2] ||
			    got[5:3] !== want[5:3] || got[13:6] !== want[13:6]) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("output %0d: expected gate %0b end %0b run %0b step %0d pitch %0d",
						checked, want[0], want[1], want[2], want[5:3], want[13:6]);
					$display("output %0d:      got gate %0b end %0b run %0b step %0d pitch %0d",
						checked, got[0], got[1], got[2], got[5:3], got[13:6]);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_outputs.size();
		endfunction
	endclass

	localparam int IDLE_LIMIT      = 3000;
	localparam int PHASES          = 16;
	localparam int PHASE_TICKS     = 102;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 12;

	// input level bits
	localparam logic [IN_TDATA_W-1:0] T_CLK   = 8'h01;
	localparam logic [IN_TDATA_W-1:0] T_RST   = 8'h02;
	localparam logic [IN_TDATA_W-1:0] T_START = 8'h04;
	localparam logic [IN_TDATA_W-1:0] T_STOP  = 8'h08;
	localparam logic [IN_TDATA_W-1:0] T_TOG   = 8'h10;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	// [0] clock_in [1] reset_in [2] start_in [3] stop_in [4] toggle_in
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	// [0] gate_out [1] end_gate_out [2] running_out [5:3] step_out [13:6] pitch_out
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_idx   = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	step_seq_checker seq_model;

	bit          no_idle  = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned idle_cycles = 0;

	// sample clock pattern state
	logic        clk_level = 1'b0;
	logic        tog_level = 1'b0;
	int unsigned half_left = 0;

	clocked_step_sequencer_gate uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned rand_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 45) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// square-wave clock level with sparse control pulses, plus some raw noise
	function automatic logic [IN_TDATA_W-1:0] make_tick();
		logic [IN_TDATA_W-1:0] d;
		if ($urandom_range(0, 9) == 0) return IN_TDATA_W'($urandom_range(0, 31));
		if (half_left == 0) begin
			clk_level = !clk_level;
			half_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
		end else begin
			half_left--;
		end
		if ($urandom_range(0, 24) == 0) tog_level = !tog_level;
		d    = '0;
		d[0] = clk_level;
		d[1] = ($urandom_range(0, 39) == 0);
		d[2] = ($urandom_range(0, 29) == 0);
		d[3] = ($urandom_range(0, 59) == 0);
		d[4] = tog_level;
		return d;
	endfunction

	task automatic send_tick(input logic [IN_TDATA_W-1:0] d);
		int unsigned gap;
		gap = rand_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		seq_model.set_reg(idx, v);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] mask, pulses, modes, pitches,
	                         fraction, loop_on);
		write_reg(REG_STEP_ENABLE, mask);
		write_reg(REG_PULSE_COUNTS, pulses);
		write_reg(REG_GATE_MODES, modes);
		write_reg(REG_STEP_PITCHES, pitches);
		write_reg(REG_GATE_FRAC, fraction);
		write_reg(REG_LOOPING, loop_on);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (seq_model.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// transfer monitor, checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				seq_model.note_tick(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				seq_model.check_output(m_tdata);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else if (++idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// output side: random back-pressure and one long hold-off on request
	initial begin : receiver
		int unsigned idle_left;
		int unsigned run_left;
		int unsigned hold_left;
		idle_left = 0;
		run_left  = 1;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (idle_left > 0 && !no_idle) begin
				m_tready <= 1'b0;
				idle_left--;
			end else begin
				m_tready <= 1'b1;
				if (run_left > 1) begin
					run_left--;
				end else begin
					idle_left = rand_gap();
					run_left  = $urandom_range(1, 24);
				end
			end
		end
	end

	initial begin : stimulus
		logic [IN_TDATA_W-1:0] directed_ticks [$];
		seq_model = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// start from idle with a zero period, edges, toggles, stop, reset, all-ones
		configure(64'hFF, 64'h0, 64'h0, 64'hFF80_4020_1008_0401, 64'd192, 64'd1);
		directed_ticks = '{8'h00, T_START, 8'h00, T_CLK, 8'h00, 8'h00, T_CLK, 8'h00,
			T_TOG, 8'h00, T_TOG, 8'h00, T_TOG, T_STOP, T_RST, T_CLK, 8'h00, T_CLK,
			T_START | T_STOP, 8'h1F, 8'h00, 8'h1F, 8'h00, T_RST | T_START};
		foreach (directed_ticks[i]) send_tick(directed_ticks[i]);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					configure(64'hFF, 64'hFF_FFFF, 64'hAAAA, '1, 64'd243, 64'd0);
				end
				1: begin
					// every step skipped
					configure(64'h00, 64'h0, 64'h0, 64'h0, 64'd13, 64'd1);
				end
				2: begin
					configure(64'h01, 64'($urandom), 64'h5555, {$urandom, $urandom},
						64'd13, 64'd0);
				end
				3: begin
					configure(64'h80, 64'($urandom), 64'hFFFF, {$urandom, $urandom},
						64'd243, 64'd1);
				end
				default: begin
					configure(($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 255)) :
						64'($urandom_range(1, 255)), 64'($urandom), 64'($urandom),
						{$urandom, $urandom}, 64'($urandom_range(13, 243)),
						64'($urandom_range(0, 1)));
				end
			endcase
			no_idle = (p == 3 || p == 9);
			if (p == 5) hold_req = 1'b1;
			repeat (PHASE_TICKS) send_tick(make_tick());
			drain();
		end

		if (seq_model.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
